>>> rtl/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types, codes and constants of the dispense motor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

	localparam int RELEASE_TICKS_DEF  = 200;
	localparam int CONFIRM_NEEDED_DEF = 7;

	localparam int TICK_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int WSTEP_W  = 3;
	localparam int WLEN_W   = 7;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DISPENSE_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ENABLE   = 2'd2;

	localparam logic [TICK_W-1:0] DISPENSE_TIMEOUT_RST = 16'd500;
	localparam logic [TICK_W-1:0] SETTLE_TICKS_RST     = 16'd0;
	localparam logic              REVERSE_ENABLE_RST   = 1'b1;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

	localparam logic ERR_NONE          = 1'b0;
	localparam logic ERR_MOTOR_TIMEOUT = 1'b1;

	localparam logic [1:0] DRIVE_STOP    = 2'd0;
	localparam logic [1:0] DRIVE_FORWARD = 2'd1;
	localparam logic [1:0] DRIVE_REVERSE = 2'd2;

	localparam logic [WSTEP_W-1:0] WIGGLE_STEPS = 3'd5;

	typedef logic [1:0] drive_t;

	// reverse 100, then forward/reverse 50 each
	function automatic logic [WLEN_W-1:0] wiggle_len(input logic [WSTEP_W-1:0] step);
		logic [WLEN_W-1:0] len;
		unique case (step)
			3'd0:    len = 7'd100;
			default: len = 7'd50;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dms_in_if.sv
// ----------------------------------------------------------------------------
// dms_in_if
// Command channel: a tick or a job start with the switch sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic       switch_level;
	logic [7:0] portion_count;

	modport source (output valid, output mode, output switch_level,
		output portion_count, input ready);
	modport sink (input valid, input mode, input switch_level,
		input portion_count, output ready);
endinterface

`default_nettype wire

>>> rtl/dms_out_if.sv
// ----------------------------------------------------------------------------
// dms_out_if
// Result channel: drive command, status and portion count per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] motor_drive;
	logic       busy_res;
	logic       job_finished;
	logic       error_code;
	logic [7:0] portions_dispensed;

	modport source (output valid, output motor_drive, output busy_res,
		output job_finished, output error_code, output portions_dispensed,
		input ready);
	modport sink (input valid, input motor_drive, input busy_res,
		input job_finished, input error_code, input portions_dispensed,
		output ready);
endinterface

`default_nettype wire

>>> rtl/dispense_motor_sequencer.sv
// ----------------------------------------------------------------------------
// dispense_motor_sequencer
// Portion dispensing motor controller with stall wiggle and retry.
// ----------------------------------------------------------------------------
// Takes one command beat per clock while cmd.ready is high and returns one
// result beat per command. A command is registered in the command stage,
// then the sequencer state and the result register are updated from it
// once the result side can advance. The result register decouples the
// two channels; a stalled result holds the command stage, which in turn
// lowers cmd.ready. Configuration writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
`default_nettype none

module dispense_motor_sequencer #(
	parameter int RELEASE_TICKS  = dms_pkg::RELEASE_TICKS_DEF,
	parameter int CONFIRM_NEEDED = dms_pkg::CONFIRM_NEEDED_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	dms_in_if.sink                         cmd,
	dms_out_if.source                      rsp,
	input  wire                            cfg_we,
	input  wire [dms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [dms_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(CONFIRM_NEEDED + 1);
	localparam int TW = dms_pkg::TICK_W;
	localparam int NW = dms_pkg::COUNT_W;
	localparam int SW = dms_pkg::WSTEP_W;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_RELEASE = 3'd1,
		PH_SEEK    = 3'd2,
		PH_SETTLE  = 3'd3,
		PH_WIGGLE  = 3'd4
	} phase_t;

	// configuration
	logic [TW-1:0] dispense_timeout_q;
	logic [TW-1:0] settle_ticks_q;
	logic          reverse_enable_q;

	// sequencer state
	phase_t        phase_q;
	logic [TW-1:0] phase_ticks_q;
	logic [CW-1:0] confirm_count_q;
	logic          confirm_pending_q;
	logic          wiggle_used_q;
	logic [SW-1:0] wiggle_step_q;
	logic [NW-1:0] portions_left_q;
	logic [NW-1:0] portions_done_q;

	// command stage
	logic          valid_s1;
	logic          mode_s1;
	logic          switch_s1;
	logic [NW-1:0] count_s1;

	// result register
	logic                 res_valid_q;
	dms_pkg::drive_t      drive_q;
	logic                 busy_q;
	logic                 finished_q;
	logic                 error_q;
	logic [NW-1:0]        done_out_q;

	logic advance;
	assign advance   = !res_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || advance;

	// next state
	phase_t          phase_n;
	logic [TW-1:0]   ticks_n;
	logic [CW-1:0]   cc_n;
	logic            pend_n;
	logic            wu_n;
	logic [SW-1:0]   ws_n;
	logic [NW-1:0]   left_n;
	logic [NW-1:0]   done_n;
	logic            fin_n;
	logic            err_n;
	dms_pkg::drive_t drive_n;

	logic [TW-1:0]   ticks_inc;
	logic [CW-1:0]   cc_inc;
	logic [SW-1:0]   ws_inc;
	logic [TW-1:0]   limit;
	logic            do_stall;
	logic            do_settle;
	logic            do_after;

	always_comb begin
		phase_n   = phase_q;
		ticks_n   = phase_ticks_q;
		cc_n      = confirm_count_q;
		pend_n    = confirm_pending_q;
		wu_n      = wiggle_used_q;
		ws_n      = wiggle_step_q;
		left_n    = portions_left_q;
		done_n    = portions_done_q;
		fin_n     = 1'b0;
		err_n     = dms_pkg::ERR_NONE;
		do_stall  = 1'b0;
		do_settle = 1'b0;
		do_after  = 1'b0;
		ticks_inc = phase_ticks_q + TW'(1);
		cc_inc    = confirm_count_q + CW'(1);
		ws_inc    = wiggle_step_q + SW'(1);
		limit     = (dispense_timeout_q == '0) ? TW'(1) : dispense_timeout_q;

		if (mode_s1 == dms_pkg::MODE_START) begin
			if (phase_q == PH_IDLE) begin
				done_n = '0;
				left_n = count_s1;
				if (count_s1 == '0) begin
					fin_n = 1'b1;
				end else begin
					phase_n = PH_RELEASE;
					ticks_n = '0;
					cc_n    = '0;
					pend_n  = 1'b0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_RELEASE: begin
					if (switch_s1) begin
						phase_n = PH_SEEK;
						ticks_n = '0;
					end else begin
						ticks_n = ticks_inc;
						if (ticks_inc >= TW'(RELEASE_TICKS))
							do_stall = 1'b1;
					end
				end
				PH_SEEK: begin
					if (!confirm_pending_q && !switch_s1) begin
						pend_n = 1'b1;
					end else begin
						if (confirm_pending_q) begin
							pend_n = 1'b0;
							if (!switch_s1) begin
								cc_n = cc_inc;
								if (cc_inc >= CW'(CONFIRM_NEEDED)) begin
									cc_n      = '0;
									done_n    = portions_done_q + NW'(1);
									left_n    = portions_left_q - NW'(1);
									do_settle = 1'b1;
								end
							end
						end
						if (!do_settle) begin
							ticks_n = ticks_inc;
							if (ticks_inc >= limit)
								do_stall = 1'b1;
						end
					end
				end
				PH_SETTLE: begin
					ticks_n = ticks_inc;
					if (ticks_inc >= settle_ticks_q)
						do_after = 1'b1;
				end
				PH_WIGGLE: begin
					ticks_n = ticks_inc;
					if (ticks_inc >= TW'(dms_pkg::wiggle_len(wiggle_step_q))) begin
						ticks_n = '0;
						if (ws_inc >= dms_pkg::WIGGLE_STEPS) begin
							ws_n      = '0;
							do_settle = 1'b1;
						end else begin
							ws_n = ws_inc;
						end
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		if (do_stall) begin
			if (reverse_enable_q && !wiggle_used_q) begin
				wu_n    = 1'b1;
				ws_n    = '0;
				ticks_n = '0;
				phase_n = PH_WIGGLE;
			end else begin
				wu_n    = 1'b0;
				phase_n = PH_IDLE;
				fin_n   = 1'b1;
				err_n   = dms_pkg::ERR_MOTOR_TIMEOUT;
			end
		end

		if (do_settle) begin
			ticks_n = '0;
			if (settle_ticks_q == '0)
				do_after = 1'b1;
			else
				phase_n = PH_SETTLE;
		end

		if (do_after) begin
			if (left_n == '0) begin
				phase_n = PH_IDLE;
				fin_n   = 1'b1;
			end else begin
				phase_n = PH_RELEASE;
				ticks_n = '0;
				cc_n    = '0;
				pend_n  = 1'b0;
			end
		end

		if (phase_n == PH_IDLE)
			drive_n = dms_pkg::DRIVE_STOP;
		else if (phase_n == PH_WIGGLE && !ws_n[0])
			drive_n = dms_pkg::DRIVE_REVERSE;
		else
			drive_n = dms_pkg::DRIVE_FORWARD;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dispense_timeout_q <= dms_pkg::DISPENSE_TIMEOUT_RST;
			settle_ticks_q     <= dms_pkg::SETTLE_TICKS_RST;
			reverse_enable_q   <= dms_pkg::REVERSE_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dms_pkg::CFG_DISPENSE_TIMEOUT: dispense_timeout_q <= cfg_data;
				dms_pkg::CFG_SETTLE_TICKS:     settle_ticks_q     <= cfg_data;
				dms_pkg::CFG_REVERSE_ENABLE:   reverse_enable_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// command stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			mode_s1   <= cmd.mode;
			switch_s1 <= cmd.switch_level;
			count_s1  <= cmd.portion_count;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_IDLE;
			phase_ticks_q     <= '0;
			confirm_count_q   <= '0;
			confirm_pending_q <= 1'b0;
			wiggle_used_q     <= 1'b0;
			wiggle_step_q     <= '0;
			portions_left_q   <= '0;
			portions_done_q   <= '0;
			res_valid_q       <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q           <= phase_n;
				phase_ticks_q     <= ticks_n;
				confirm_count_q   <= cc_n;
				confirm_pending_q <= pend_n;
				wiggle_used_q     <= wu_n;
				wiggle_step_q     <= ws_n;
				portions_left_q   <= left_n;
				portions_done_q   <= done_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q    <= drive_n;
			busy_q     <= (phase_n != PH_IDLE);
			finished_q <= fin_n;
			error_q    <= err_n;
			done_out_q <= done_n;
		end
	end

	assign rsp.valid              = res_valid_q;
	assign rsp.motor_drive        = drive_q;
	assign rsp.busy_res           = busy_q;
	assign rsp.job_finished       = finished_q;
	assign rsp.error_code         = error_q;
	assign rsp.portions_dispensed = done_out_q;

	// checks
	a_err_needs_finish: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && error_q |-> finished_q)
		else $error("error without job end");

	a_stop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !busy_q |-> drive_q == dms_pkg::DRIVE_STOP)
		else $error("motor driven while idle");

	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(mode_s1) && $stable(count_s1))
		else $error("command beat lost under back-pressure");

	a_wiggle_range: assert property (@(posedge clk) disable iff (!arst_n)
		wiggle_step_q < dms_pkg::WIGGLE_STEPS)
		else $error("wiggle step out of range");

	a_confirm_range: assert property (@(posedge clk) disable iff (!arst_n)
		confirm_count_q < CW'(CONFIRM_NEEDED))
		else $error("confirm count overran");

endmodule

`default_nettype wire

>>> dv/dms_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dms_checker
// Predicts and checks every result beat of the dispense motor sequencer.
// ----------------------------------------------------------------------------
// Mirrors register writes, steps its own copy of the sequencer for each
// accepted command beat and compares each accepted result beat, field by
// field, against the oldest prediction. Failures are counted for the top.
`default_nettype none

module dms_checker
	import dms_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	dms_in_if                     cmd,
	dms_out_if                    rsp,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire                   end_check,
	output int                    fail_count
);

	localparam int WIGGLE_FIRST = 100;
	localparam int WIGGLE_REST  = 50;

	typedef enum logic [2:0] {
		PH_IDLE, PH_RELEASE, PH_SEEK, PH_SETTLE, PH_WIGGLE
	} phase_t;

	typedef struct packed {
		drive_t             drive;
		logic               busy;
		logic               finished;
		logic               err;
		logic [COUNT_W-1:0] done;
	} status_t;

	status_t              status_q[$];

	logic [TICK_W-1:0]    timeout_r;
	logic [TICK_W-1:0]    settle_r;
	logic                 rev_en_r;

	phase_t               ph;
	logic [TICK_W-1:0]    ph_ticks;
	logic [3:0]           confirms;
	logic                 pending;
	logic                 wiggled;
	logic [WSTEP_W-1:0]   wstep;
	logic [COUNT_W-1:0]   left_cnt;
	logic [COUNT_W-1:0]   done_cnt;

	function automatic void start_portion();
		ph       = PH_RELEASE;
		ph_ticks = '0;
		confirms = '0;
		pending  = 1'b0;
	endfunction

	// returns one when the job is over
	function automatic logic close_portion();
		if (left_cnt == 0) begin
			ph = PH_IDLE;
			return 1'b1;
		end
		start_portion();
		return 1'b0;
	endfunction

	function automatic logic begin_settle();
		ph_ticks = '0;
		if (settle_r == 0)
			return close_portion();
		ph = PH_SETTLE;
		return 1'b0;
	endfunction

	// returns one when the stall ends the job
	function automatic logic motor_stall();
		if (rev_en_r && !wiggled) begin
			wiggled  = 1'b1;
			wstep    = '0;
			ph_ticks = '0;
			ph       = PH_WIGGLE;
			return 1'b0;
		end
		wiggled = 1'b0;
		ph      = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic status_t dispense_step(logic mode, logic sw, logic [COUNT_W-1:0] count);
		status_t           st;
		logic              fin;
		logic              err;
		logic              counted;
		logic [TICK_W-1:0] limit;
		fin     = 1'b0;
		err     = 1'b0;
		counted = 1'b0;
		limit   = (timeout_r == 0) ? TICK_W'(1) : timeout_r;
		if (mode == MODE_START) begin
			if (ph == PH_IDLE) begin
				done_cnt = '0;
				left_cnt = count;
				if (count == 0)
					fin = 1'b1;
				else
					start_portion();
			end
		end else begin
			case (ph)
				PH_RELEASE: begin
					if (sw) begin
						ph       = PH_SEEK;
						ph_ticks = '0;
					end else begin
						ph_ticks++;
						if (ph_ticks >= RELEASE_TICKS_DEF) begin
							err = motor_stall();
							fin = err;
						end
					end
				end
				PH_SEEK: begin
					if (!pending && !sw) begin
						pending = 1'b1;
					end else begin
						if (pending) begin
							pending = 1'b0;
							if (!sw) begin
								confirms++;
								if (confirms >= CONFIRM_NEEDED_DEF) begin
									confirms = '0;
									done_cnt++;
									left_cnt--;
									fin     = begin_settle();
									counted = 1'b1;
								end
							end
						end
						if (!counted) begin
							ph_ticks++;
							if (ph_ticks >= limit) begin
								err = motor_stall();
								fin = err;
							end
						end
					end
				end
				PH_SETTLE: begin
					ph_ticks++;
					if (ph_ticks >= settle_r)
						fin = close_portion();
				end
				PH_WIGGLE: begin
					ph_ticks++;
					if (ph_ticks >= ((wstep == 0) ? WIGGLE_FIRST : WIGGLE_REST)) begin
						ph_ticks = '0;
						wstep++;
						if (wstep >= WIGGLE_STEPS) begin
							wstep = '0;
							fin   = begin_settle();
						end
					end
				end
				default: ph = PH_IDLE;
			endcase
		end

		if (ph == PH_IDLE)
			st.drive = DRIVE_STOP;
		else if (ph == PH_WIGGLE)
			st.drive = wstep[0] ? DRIVE_FORWARD : DRIVE_REVERSE;
		else
			st.drive = DRIVE_FORWARD;
		st.busy     = (ph != PH_IDLE);
		st.finished = fin;
		st.err      = err ? ERR_MOTOR_TIMEOUT : ERR_NONE;
		st.done     = done_cnt;
		return st;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		status_t want;
		if (!arst_n) begin
			timeout_r  = DISPENSE_TIMEOUT_RST;
			settle_r   = SETTLE_TICKS_RST;
			rev_en_r   = REVERSE_ENABLE_RST;
			ph         = PH_IDLE;
			ph_ticks   = '0;
			confirms   = '0;
			pending    = 1'b0;
			wiggled    = 1'b0;
			wstep      = '0;
			left_cnt   = '0;
			done_cnt   = '0;
			fail_count = 0;
			status_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DISPENSE_TIMEOUT: timeout_r = cfg_data;
					CFG_SETTLE_TICKS:     settle_r  = cfg_data;
					CFG_REVERSE_ENABLE:   rev_en_r  = cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				status_q.push_back(dispense_step(cmd.mode, cmd.switch_level,
					cmd.portion_count));
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					$error("result beat with no prediction pending");
					fail_count++;
				end else begin
					want = status_q.pop_front();
					check_field("motor_drive", 32'(want.drive), 32'(rsp.motor_drive));
					check_field("busy_res", 32'(want.busy), 32'(rsp.busy_res));
					check_field("job_finished", 32'(want.finished),
						32'(rsp.job_finished));
					check_field("error_code", 32'(want.err), 32'(rsp.error_code));
					check_field("portions_dispensed", 32'(want.done),
						32'(rsp.portions_dispensed));
				end
			end
			if (end_check && status_q.size() != 0) begin
				$error("%0d predicted results never arrived", status_q.size());
				fail_count++;
				status_q.delete();
			end
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dispense motor sequencer.
// ----------------------------------------------------------------------------
// Drives directed jobs, then well-formed portion sequences with noise, stalls
// and wiggle retries across several register settings. Both channels idle at
// random; dms_checker does the prediction and comparison.
`default_nettype none

module tb_top;
	import dms_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_ITEMS    = 850;
	localparam int SETTLE_FILL_MAX = 16;
	localparam int SEEK_STALL_MAX  = 64;
	localparam int WIGGLE_TICKS    = 300;
	localparam int DRAIN_CYCLES    = 4;
	localparam int JOB_TICKS_MAX   = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  end_check;
	int                    fail_count;

	int                    sent = 0;
	int                    received = 0;
	int                    idle_cycles = 0;
	logic                  last_busy = 1'b0;
	logic                  quiet = 1'b0;
	logic [TICK_W-1:0]     cur_timeout = DISPENSE_TIMEOUT_RST;
	logic [TICK_W-1:0]     cur_settle = SETTLE_TICKS_RST;

	dms_in_if  cmd_if();
	dms_out_if rsp_if();

	dispense_motor_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dms_checker u_dispense_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.rsp        (rsp_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.end_check  (end_check),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_sink
		int gap;
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			repeat (gap) begin
				rsp_if.ready <= 1'b0;
				@(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			last_busy = rsp_if.busy_res;
			received++;
		end
	end

	task automatic send_beat(input logic mode, input logic sw, input logic [COUNT_W-1:0] count);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid         <= 1'b1;
		cmd_if.mode          <= mode;
		cmd_if.switch_level  <= sw;
		cmd_if.portion_count <= count;
		do @(posedge clk); while (!cmd_if.ready);
		sent++;
	endtask

	task automatic tick_beat(input logic sw);
		send_beat(MODE_TICK, sw, COUNT_W'($urandom));
	endtask

	// drops cmd valid, then waits on the clock until every sent beat has its result
	task automatic wait_results();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (received != sent);
	endtask

	task automatic finish_job();
		int n;
		n = 0;
		wait_results();
		while (last_busy && n < JOB_TICKS_MAX) begin
			tick_beat(1'($urandom_range(0, 1)));
			wait_results();
			n++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [TICK_W-1:0] timeout, input logic [TICK_W-1:0] settle,
		input logic rev);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_DISPENSE_TIMEOUT, timeout);
		write_reg(CFG_SETTLE_TICKS, settle);
		write_reg(CFG_REVERSE_ENABLE, CFG_DATA_W'(rev));
		cur_timeout = timeout;
		cur_settle  = settle;
	endtask

	task automatic run_job(input logic [COUNT_W-1:0] count);
		int                k;
		logic [TICK_W-1:0] lim;
		lim = (cur_timeout == 0) ? TICK_W'(1) : cur_timeout;
		send_beat(MODE_START, 1'($urandom_range(0, 1)), count);
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 13) == 0) begin
				// force a stall, then ride out the wiggle if one is granted
				if (lim <= SEEK_STALL_MAX && $urandom_range(0, 1) == 1) begin
					tick_beat(1'b1);
					repeat (lim) tick_beat(1'b1);
				end else begin
					repeat (RELEASE_TICKS_DEF) tick_beat(1'b0);
				end
				wait_results();
				if (!last_busy)
					break;
				repeat (WIGGLE_TICKS) tick_beat(1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(0, 4)) tick_beat(1'b0);
				tick_beat(1'b1);
				repeat (CONFIRM_NEEDED_DEF) begin
					if ($urandom_range(0, 7) == 0)
						tick_beat(1'b1);
					tick_beat(1'b0);
					tick_beat(1'b0);
				end
			end
			if (cur_settle <= SETTLE_FILL_MAX)
				repeat (cur_settle) tick_beat(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 15) == 0) begin
				// start while busy only; an idle block would take it as a new job
				wait_results();
				if (last_busy)
					send_beat(MODE_START, 1'($urandom_range(0, 1)), COUNT_W'($urandom));
			end
		end
		finish_job();
	endtask

	initial begin : stimulus
		int phase_end;
		cmd_if.valid         <= 1'b0;
		cmd_if.mode          <= MODE_TICK;
		cmd_if.switch_level  <= 1'b1;
		cmd_if.portion_count <= '0;
		cfg_we               <= 1'b0;
		cfg_index            <= CFG_DISPENSE_TIMEOUT;
		cfg_data             <= '0;
		end_check            <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks, empty job, one clean portion with a start while busy
		tick_beat(1'b0);
		tick_beat(1'b1);
		send_beat(MODE_START, 1'b0, 8'd0);
		send_beat(MODE_START, 1'b1, 8'd1);
		send_beat(MODE_START, 1'b0, 8'hff);
		tick_beat(1'b0);
		tick_beat(1'b1);
		tick_beat(1'b0);
		tick_beat(1'b1);
		repeat (2 * CONFIRM_NEEDED_DEF) tick_beat(1'b0);
		finish_job();

		// full-count job dies on the first seek tick
		set_config(16'd1, 16'd0, 1'b0);
		send_beat(MODE_START, 1'b1, 8'hff);
		tick_beat(1'b1);
		tick_beat(1'b1);
		finish_job();

		// long settle never reached: release stall ends the job
		set_config(16'hffff, 16'hffff, 1'b0);
		send_beat(MODE_START, 1'b0, 8'd3);
		repeat (RELEASE_TICKS_DEF) tick_beat(1'b0);
		finish_job();

		set_config(16'd0, 16'd2, 1'b1);
		run_job(8'd1);
		run_job(8'd2);

		set_config(16'hffff, 16'd0, 1'b1);
		run_job(8'd3);

		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0:       cur_timeout = 16'd0;
				1:       cur_timeout = 16'hffff;
				2:       cur_timeout = TICK_W'($urandom_range(1, 8));
				default: cur_timeout = TICK_W'($urandom_range(9, 60));
			endcase
			set_config(cur_timeout,
				($urandom_range(0, 1) == 0) ? TICK_W'(0) : TICK_W'($urandom_range(1, 6)),
				1'($urandom_range(0, 1)));
			phase_end = sent + $urandom_range(60, 120);
			while (sent < phase_end) begin
				quiet = ($urandom_range(0, 3) == 0);
				run_job(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4)));
			end
		end

		quiet = 1'b0;
		wait_results();
		repeat (8) @(posedge clk);
		end_check <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
